[rtl/region_track_association_unit_macros.svh]
// Assertion macros for the region track association unit.
`ifndef REGION_TRACK_ASSOCIATION_UNIT_MACROS_SVH
`define REGION_TRACK_ASSOCIATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define RTA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rta: implication check failed");
// Next-cycle implication, held off during reset.
`define RTA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rta: next-cycle check failed");
`else
`define RTA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RTA_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/rta_pkg.sv]
// Types, constants and helper functions of the region track association unit.
`default_nettype none
package rta_pkg;

    localparam int COORD_BITS = 10;
    localparam int IDX_BITS   = 8;
    localparam int COL_BITS   = 8;
    localparam int DIST_BITS  = 10;
    localparam int SUM_BITS   = 32;
    localparam int CNT_BITS   = 24;
    localparam int QUO_BITS   = 8;
    localparam int STEP_BITS  = 4;
    localparam int CAND_BITS  = 2;
    localparam int Q_PTR_BITS = 1;
    localparam int Q_DEPTH    = 2;
    localparam int Q_CNT_BITS = 2;
    localparam int N_COL      = 3;

    localparam logic [STEP_BITS-1:0] DIV_FIRST = STEP_BITS'(QUO_BITS);
    localparam logic [DIST_BITS-1:0] DIST_ONES = '1;
    localparam logic [CAND_BITS-1:0] CAND_MAX  = '1;
    localparam logic [CNT_BITS-1:0]  CNT_MAX   = '1;
    localparam logic [COL_BITS-1:0]  MEAN_MAX  = '1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COL_BITS-1:0]   t_colour;

    // One input word as it arrives on the port
    typedef struct packed {
        logic [IDX_BITS-1:0] region_index;
        t_coord              centre_x;
        t_coord              centre_y;
        t_coord              box_left;
        t_coord              box_right;
        t_coord              box_top;
        t_coord              box_bottom;
        t_colour             mean_red;
        t_colour             mean_green;
        t_colour             mean_blue;
        logic                frame_end;
        logic                frame_empty;
    } t_in_item;

    // One result word
    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] tracked_region;
        t_coord              out_centre_x;
        t_coord              out_centre_y;
        t_coord              out_left;
        t_coord              out_right;
        t_coord              out_top;
        t_coord              out_bottom;
    } t_out_item;

    // Word class set by the front end
    typedef enum logic [1:0] {
        K_REGION,
        K_REGION_END,
        K_END_EMPTY
    } t_kind;

    // Position of a region or of the track
    typedef struct packed {
        logic [IDX_BITS-1:0] index;
        t_coord              centre_x;
        t_coord              centre_y;
        t_coord              left;
        t_coord              right;
        t_coord              top;
        t_coord              bottom;
    } t_track;

    // Word held in the queue between front and back
    typedef struct packed {
        t_kind   kind;
        t_track  pos;
        t_colour red;
        t_colour green;
        t_colour blue;
    } t_q_word;

    typedef enum logic {
        BK_RUN,
        BK_DIV
    } t_back_state;

    typedef struct packed {
        logic busy;
    } t_back_status;

    function automatic t_colour absdiff(input t_colour a, input t_colour b);
        t_colour d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

    // Colour sum with saturation at all ones
    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                    input t_colour c);
        logic [SUM_BITS:0] t;
        t = {1'b0, s} + {{(SUM_BITS+1-COL_BITS){1'b0}}, c};
        return t[SUM_BITS] ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/rta_in_if.sv]
// Input channel of the region track association unit.
`default_nettype none
interface rta_in_if;
    logic                valid;
    logic                ready;
    rta_pkg::t_in_item   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/rta_out_if.sv]
// Result channel of the region track association unit.
`default_nettype none
interface rta_out_if;
    logic                valid;
    logic                ready;
    rta_pkg::t_out_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/region_track_association_unit.sv]
// An accepted word passes the front register and the queue to the back end; a frame result
// enters the result register as the frame-ending word is taken. Throughput: one word per
// cycle, held while a result waits at a frame end or a matched frame-end after the first
// match runs the mean divider (a clamp test, then one quotient bit per cycle per colour).
// Reset (i_rst_n low, synchronous) empties front register, queue and result register and
// clears track, colour sums, count and mean to zero.
`default_nettype none
`include "region_track_association_unit_macros.svh"
module region_track_association_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rta_in_if.sink      i_in,
    rta_out_if.source   o_out
);

    rta_pkg::t_q_word       f_word;
    logic                   f_valid;
    logic                   q_ready;
    rta_pkg::t_q_word       q_word;
    logic                   q_valid;
    logic                   b_pop;
    rta_pkg::t_back_status  b_status;
    logic                   w_end_pop;
    logic                   w_held_pop;

    rta_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_word  (f_word),
        .o_valid (f_valid),
        .i_ready (q_ready)
    );

    rta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (f_word),
        .i_push  (f_valid),
        .o_ready (q_ready),
        .o_word  (q_word),
        .o_valid (q_valid),
        .i_pop   (b_pop)
    );

    rta_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (q_word),
        .i_word_valid (q_valid),
        .o_pop        (b_pop),
        .o_out        (o_out),
        .o_status     (b_status)
    );

    // Frame-ending pops, and pops while a result is held
    assign w_end_pop  = b_pop && (q_word.kind != rta_pkg::K_REGION);
    assign w_held_pop = b_pop && o_out.valid && !o_out.ready;

    // Checks
    `RTA_ASSERT_IMP(a_pop_needs_word, i_clk, i_rst_n, b_pop, q_valid)
    `RTA_ASSERT_IMP(a_no_pop_in_divide, i_clk, i_rst_n, b_status.busy, !b_pop)
    `RTA_ASSERT_IMP(a_no_end_over_held_result, i_clk, i_rst_n, w_held_pop, !w_end_pop)
    `RTA_ASSERT_NXT(a_end_gives_result, i_clk, i_rst_n, w_end_pop, o_out.valid)

endmodule
`default_nettype wire

[rtl/rta_front.sv]
// Front end: takes input words, classifies them and hands them to the queue.
`default_nettype none
module rta_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    rta_in_if.sink               i_in,
    output rta_pkg::t_q_word     o_word,
    output logic                 o_valid,
    input  wire logic            i_ready
);

    rta_pkg::t_q_word r_word;
    logic             r_valid;
    rta_pkg::t_q_word n_word;

    assign i_in.ready = !r_valid || i_ready;
    assign o_word     = r_word;
    assign o_valid    = r_valid;

    // Classify: an empty marker carries no region even with frame_end set
    always_comb begin
        n_word.pos.index    = i_in.payload.region_index;
        n_word.pos.centre_x = i_in.payload.centre_x;
        n_word.pos.centre_y = i_in.payload.centre_y;
        n_word.pos.left     = i_in.payload.box_left;
        n_word.pos.right    = i_in.payload.box_right;
        n_word.pos.top      = i_in.payload.box_top;
        n_word.pos.bottom   = i_in.payload.box_bottom;
        n_word.red          = i_in.payload.mean_red;
        n_word.green        = i_in.payload.mean_green;
        n_word.blue         = i_in.payload.mean_blue;
        priority if (i_in.payload.frame_empty) begin
            n_word.kind = rta_pkg::K_END_EMPTY;
        end else if (i_in.payload.frame_end) begin
            n_word.kind = rta_pkg::K_REGION_END;
        end else begin
            n_word.kind = rta_pkg::K_REGION;
        end
    end

    // Occupancy of the front register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Word register
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word <= n_word;
        end
    end

endmodule
`default_nettype wire

[rtl/rta_queue.sv]
// Two-word queue between front end and back end.
`default_nettype none
module rta_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rta_pkg::t_q_word   i_word,
    input  wire logic               i_push,
    output logic                    o_ready,
    output rta_pkg::t_q_word        o_word,
    output logic                    o_valid,
    input  wire logic               i_pop
);

    rta_pkg::t_q_word                  r_mem [rta_pkg::Q_DEPTH];
    logic [rta_pkg::Q_PTR_BITS-1:0]    r_wp;
    logic [rta_pkg::Q_PTR_BITS-1:0]    r_rp;
    logic [rta_pkg::Q_CNT_BITS-1:0]    r_cnt;
    logic                              w_push;
    logic                              w_pop;

    assign o_ready = (r_cnt != rta_pkg::Q_CNT_BITS'(rta_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule
`default_nettype wire

[rtl/rta_back.sv]
// Back end: candidate test, best-match selection, frame result and mean update.
`default_nettype none
module rta_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rta_pkg::t_q_word   i_word,
    input  wire logic               i_word_valid,
    output logic                    o_pop,
    rta_out_if.source               o_out,
    output rta_pkg::t_back_status   o_status
);

    // Control and track state
    rta_pkg::t_back_state               r_state;
    rta_pkg::t_back_state               n_state;
    logic                               r_started;
    logic                               r_missed;
    rta_pkg::t_track                    r_trk;
    logic [rta_pkg::CAND_BITS-1:0]      r_cand_cnt;
    logic [rta_pkg::DIST_BITS-1:0]      r_best_dist;
    logic [rta_pkg::SUM_BITS-1:0]       r_sum  [rta_pkg::N_COL];
    logic [rta_pkg::CNT_BITS-1:0]       r_frames;
    rta_pkg::t_colour                   r_mean [rta_pkg::N_COL];
    logic [rta_pkg::STEP_BITS-1:0]      r_step;
    logic                               r_out_valid;

    // Payload registers
    rta_pkg::t_track                    r_best;
    rta_pkg::t_colour                   r_best_col [rta_pkg::N_COL];
    rta_pkg::t_out_item                 r_out;
    logic [rta_pkg::SUM_BITS-1:0]       r_rem  [rta_pkg::N_COL];
    logic [rta_pkg::SUM_BITS-1:0]       r_div;
    rta_pkg::t_colour                   r_quo  [rta_pkg::N_COL];
    logic                               r_sat  [rta_pkg::N_COL];

    // Combinational
    rta_pkg::t_colour                   w_col [rta_pkg::N_COL];
    logic                               w_is_region;
    logic                               w_is_end;
    logic                               w_inside;
    logic                               w_overlap;
    logic [rta_pkg::DIST_BITS-1:0]      w_dist;
    logic                               w_cand;
    logic                               w_take;
    logic [rta_pkg::CAND_BITS-1:0]      w_cnt_after;
    logic                               w_found;
    rta_pkg::t_track                    w_bst;
    rta_pkg::t_colour                   w_bcol [rta_pkg::N_COL];
    logic [rta_pkg::SUM_BITS-1:0]       w_new_sum [rta_pkg::N_COL];
    logic [rta_pkg::CNT_BITS-1:0]       w_new_frames;
    rta_pkg::t_out_item                 w_result;
    logic                               w_out_free;
    logic                               w_ge [rta_pkg::N_COL];
    logic                               w_start_div;

    assign w_col[0] = i_word.red;
    assign w_col[1] = i_word.green;
    assign w_col[2] = i_word.blue;

    assign w_is_region = (i_word.kind != rta_pkg::K_END_EMPTY);
    assign w_is_end    = (i_word.kind != rta_pkg::K_REGION);
    assign w_out_free  = !r_out_valid || o_out.ready;

    // Candidate tests against the tracked box, comparisons taken as given
    assign w_inside  = (i_word.pos.centre_x >= r_trk.left) && (i_word.pos.centre_x <= r_trk.right)
                    && (i_word.pos.centre_y >= r_trk.top) && (i_word.pos.centre_y <= r_trk.bottom);
    assign w_overlap = (i_word.pos.right >= r_trk.left) && (i_word.pos.left <= r_trk.right)
                    && (i_word.pos.bottom >= r_trk.top) && (i_word.pos.top <= r_trk.bottom);

    // L1 colour distance to the running mean
    assign w_dist = rta_pkg::DIST_BITS'(rta_pkg::absdiff(r_mean[0], w_col[0]))
                  + rta_pkg::DIST_BITS'(rta_pkg::absdiff(r_mean[1], w_col[1]))
                  + rta_pkg::DIST_BITS'(rta_pkg::absdiff(r_mean[2], w_col[2]));

    // Before the first match only region 0 is taken, first one only
    always_comb begin
        if (r_started) begin
            w_cand = w_is_region && (w_inside || (r_missed && w_overlap));
            w_take = w_cand && (w_dist < r_best_dist);
        end else begin
            w_cand = w_is_region && (i_word.pos.index == '0) && (r_cand_cnt == '0);
            w_take = w_cand;
        end
        if (!w_cand) begin
            w_cnt_after = r_cand_cnt;
        end else if (!r_started) begin
            w_cnt_after = rta_pkg::CAND_BITS'(1);
        end else if (r_cand_cnt == rta_pkg::CAND_MAX) begin
            w_cnt_after = r_cand_cnt;
        end else begin
            w_cnt_after = r_cand_cnt + 1'b1;
        end
        w_found = (w_cnt_after != '0);
    end

    // Best match including this word
    always_comb begin
        w_bst = w_take ? i_word.pos : r_best;
        for (int k = 0; k < rta_pkg::N_COL; k++) begin
            w_bcol[k]    = w_take ? w_col[k] : r_best_col[k];
            w_new_sum[k] = rta_pkg::sat_add(r_sum[k], w_bcol[k]);
        end
        w_new_frames = (r_frames == rta_pkg::CNT_MAX) ? r_frames : (r_frames + 1'b1);
    end

    // Frame result: the match, or the last track when lost
    always_comb begin
        w_result.found          = w_found;
        w_result.tracked_region = w_found ? w_bst.index    : r_trk.index;
        w_result.out_centre_x   = w_found ? w_bst.centre_x : r_trk.centre_x;
        w_result.out_centre_y   = w_found ? w_bst.centre_y : r_trk.centre_y;
        w_result.out_left       = w_found ? w_bst.left     : r_trk.left;
        w_result.out_right      = w_found ? w_bst.right    : r_trk.right;
        w_result.out_top        = w_found ? w_bst.top      : r_trk.top;
        w_result.out_bottom     = w_found ? w_bst.bottom   : r_trk.bottom;
    end

    // Restoring divide trial per channel
    always_comb begin
        for (int k = 0; k < rta_pkg::N_COL; k++) begin
            w_ge[k] = (r_rem[k] >= r_div);
        end
    end

    // Outputs of the sequencer
    always_comb begin
        unique case (r_state)
            rta_pkg::BK_RUN: begin
                o_pop         = i_word_valid && (!w_is_end || w_out_free);
                o_status.busy = 1'b0;
            end
            rta_pkg::BK_DIV: begin
                o_pop         = 1'b0;
                o_status.busy = 1'b1;
            end
            default: begin
                o_pop         = 1'b0;
                o_status.busy = 1'b0;
            end
        endcase
    end

    assign w_start_div = o_pop && w_is_end && w_found && r_started;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rta_pkg::BK_RUN: begin
                if (w_start_div) begin
                    n_state = rta_pkg::BK_DIV;
                end
            end
            rta_pkg::BK_DIV: begin
                if (r_step == '0) begin
                    n_state = rta_pkg::BK_RUN;
                end
            end
            default: begin
                n_state = rta_pkg::BK_RUN;
            end
        endcase
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // Control and track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rta_pkg::BK_RUN;
            r_started   <= 1'b0;
            r_missed    <= 1'b0;
            r_trk       <= '0;
            r_cand_cnt  <= '0;
            r_best_dist <= rta_pkg::DIST_ONES;
            r_frames    <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < rta_pkg::N_COL; k++) begin
                r_sum[k]  <= '0;
                r_mean[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (w_is_end) begin
                    r_out_valid <= 1'b1;
                    r_cand_cnt  <= '0;
                    r_best_dist <= rta_pkg::DIST_ONES;
                    if (w_found) begin
                        r_trk     <= w_bst;
                        r_missed  <= 1'b0;
                        r_started <= 1'b1;
                        if (r_started) begin
                            r_frames <= w_new_frames;
                            r_step   <= rta_pkg::DIV_FIRST;
                            for (int k = 0; k < rta_pkg::N_COL; k++) begin
                                r_sum[k] <= w_new_sum[k];
                            end
                        end
                    end else if (r_started) begin
                        r_missed <= 1'b1;
                    end
                end else begin
                    r_cand_cnt <= w_cnt_after;
                    if (w_take) begin
                        r_best_dist <= r_started ? w_dist : '0;
                    end
                end
            end
            // Mean written when the last quotient bit is known
            if (r_state == rta_pkg::BK_DIV) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    for (int k = 0; k < rta_pkg::N_COL; k++) begin
                        r_mean[k] <= r_sat[k] ? rta_pkg::MEAN_MAX
                                              : {r_quo[k][rta_pkg::QUO_BITS-2:0], w_ge[k]};
                    end
                end
            end
        end
    end

    // Best match, result word and divider datapath
    always_ff @(posedge i_clk) begin
        if (o_pop && w_take && !w_is_end) begin
            r_best <= i_word.pos;
            for (int k = 0; k < rta_pkg::N_COL; k++) begin
                r_best_col[k] <= w_col[k];
            end
        end
        if (o_pop && w_is_end) begin
            r_out <= w_result;
        end
        if (w_start_div) begin
            r_div <= {w_new_frames, {(rta_pkg::SUM_BITS-rta_pkg::CNT_BITS){1'b0}}};
            for (int k = 0; k < rta_pkg::N_COL; k++) begin
                r_rem[k] <= w_new_sum[k];
            end
        end else if (r_state == rta_pkg::BK_DIV) begin
            r_div <= r_div >> 1;
            for (int k = 0; k < rta_pkg::N_COL; k++) begin
                if (r_step == rta_pkg::DIV_FIRST) begin
                    // sum at or above count * 256: mean clamps
                    r_sat[k] <= w_ge[k];
                end else begin
                    if (w_ge[k]) begin
                        r_rem[k] <= r_rem[k] - r_div;
                    end
                    r_quo[k] <= {r_quo[k][rta_pkg::QUO_BITS-2:0], w_ge[k]};
                end
            end
        end
    end

endmodule
`default_nettype wire

[tb/tb_region_track_association_unit.sv]
// Self-checking testbench for the region track association unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_region_track_association_unit;
    import rta_pkg::*;

    localparam int HANG_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_WORDS = 300;

    logic i_clk;
    logic i_rst_n;

    rta_in_if  in_if ();
    rta_out_if out_if ();

    region_track_association_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // One directed stimulus row: the word, and a typed-in result where obvious
    typedef struct {
        t_in_item  w;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    // Track state mirrored by the predictor
    bit               trk_started;
    bit               trk_missed;
    t_track           trk;
    logic [31:0]      col_sum [N_COL];
    logic [23:0]      match_cnt;
    t_colour          col_mean [N_COL];
    logic [1:0]       cand_cnt;
    logic [9:0]       best_dist;
    t_track           best;
    t_colour          best_col [N_COL];

    t_out_item        track_q [$];
    t_dir_row         dir_rows [$];

    int               errors;
    int               src_idle_pct;
    int               snk_stall_pct;
    int               words_sent;
    int               found_cnt;
    int               lost_cnt;
    int               hang_cycles;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Per-frame candidate state back to its idle values
    task automatic clear_candidates();
        cand_cnt  = '0;
        best_dist = '1;
        best      = '0;
        for (int k = 0; k < N_COL; k++) best_col[k] = '0;
    endtask

    task automatic take_candidate(input t_in_item w, input logic [9:0] cdist);
        best_dist      = cdist;
        best.index     = w.region_index;
        best.centre_x  = w.centre_x;
        best.centre_y  = w.centre_y;
        best.left      = w.box_left;
        best.right     = w.box_right;
        best.top       = w.box_top;
        best.bottom    = w.box_bottom;
        best_col[0]    = w.mean_red;
        best_col[1]    = w.mean_green;
        best_col[2]    = w.mean_blue;
    endtask

    function automatic t_out_item as_result(input bit found, input t_track t);
        t_out_item r;
        r.found          = found;
        r.tracked_region = t.index;
        r.out_centre_x   = t.centre_x;
        r.out_centre_y   = t.centre_y;
        r.out_left       = t.left;
        r.out_right      = t.right;
        r.out_top        = t.top;
        r.out_bottom     = t.bottom;
        return r;
    endfunction

    // Advance the track by one accepted word; gives the frame result at frame end
    task automatic track_predict(input t_in_item w, output bit has_res, output t_out_item r);
        t_colour     wc [N_COL];
        logic [9:0]  cdist;
        bit          in_box;
        bit          overlap;
        logic [32:0] s;
        logic [31:0] m;
        wc[0]   = w.mean_red;
        wc[1]   = w.mean_green;
        wc[2]   = w.mean_blue;
        has_res = 1'b0;
        r       = '0;
        if (!w.frame_empty) begin
            if (!trk_started) begin
                // first frame: the first region numbered 0, wherever it lies
                if (w.region_index == 0 && cand_cnt == 0) begin
                    take_candidate(w, '0);
                    cand_cnt = 2'd1;
                end
            end else begin
                in_box  = w.centre_x >= trk.left && w.centre_x <= trk.right &&
                          w.centre_y >= trk.top  && w.centre_y <= trk.bottom;
                overlap = w.box_right >= trk.left && w.box_left <= trk.right &&
                          w.box_bottom >= trk.top && w.box_top <= trk.bottom;
                if (in_box || (trk_missed && overlap)) begin
                    cdist = '0;
                    for (int k = 0; k < N_COL; k++)
                        cdist = cdist + ((col_mean[k] > wc[k]) ? col_mean[k] - wc[k]
                                                               : wc[k] - col_mean[k]);
                    if (cand_cnt != 2'd3) cand_cnt = cand_cnt + 2'd1;
                    // strict compare: the earliest of equal distances stays
                    if (cdist < best_dist) take_candidate(w, cdist);
                end
            end
        end
        if (w.frame_empty || w.frame_end) begin
            has_res = 1'b1;
            if (cand_cnt != 0) begin
                r = as_result(1'b1, best);
                if (trk_started) begin
                    if (match_cnt != '1) match_cnt = match_cnt + 24'd1;
                    for (int k = 0; k < N_COL; k++) begin
                        s          = {1'b0, col_sum[k]} + best_col[k];
                        col_sum[k] = s[32] ? 32'hFFFF_FFFF : s[31:0];
                        m          = col_sum[k] / {8'd0, match_cnt};
                        col_mean[k] = (m > 32'd255) ? 8'hFF : m[7:0];
                    end
                end
                trk         = best;
                trk_missed  = 1'b0;
                trk_started = 1'b1;
            end else begin
                r = as_result(1'b0, trk);
                if (trk_started) trk_missed = 1'b1;
            end
            clear_candidates();
        end
    endtask

    function automatic t_coord clip_coord(input int v);
        return (v < 0) ? t_coord'(0) : (v > 1023) ? t_coord'(1023) : t_coord'(v);
    endfunction

    function automatic t_colour near_colour(input t_colour mean);
        int v;
        if ($urandom_range(99) < 60) begin
            v = int'(mean) + int'($urandom_range(60)) - 30;
            return (v < 0) ? t_colour'(0) : (v > 255) ? t_colour'(255) : t_colour'(v);
        end
        return t_colour'($urandom_range(255));
    endfunction

    function automatic t_in_item region(input int idx, input int cx, input int cy,
                                        input int l, input int r, input int t,
                                        input int b, input int red, input int grn,
                                        input int blu, input bit last, input bit empty);
        t_in_item w;
        w.region_index = IDX_BITS'(idx);
        w.centre_x     = t_coord'(cx);
        w.centre_y     = t_coord'(cy);
        w.box_left     = t_coord'(l);
        w.box_right    = t_coord'(r);
        w.box_top      = t_coord'(t);
        w.box_bottom   = t_coord'(b);
        w.mean_red     = t_colour'(red);
        w.mean_green   = t_colour'(grn);
        w.mean_blue    = t_colour'(blu);
        w.frame_end    = last;
        w.frame_empty  = empty;
        return w;
    endfunction

    function automatic t_in_item noise_word();
        logic [95:0] rnd;
        t_in_item    w;
        rnd = {$urandom, $urandom, $urandom};
        w   = rnd[$bits(t_in_item)-1:0];
        return w;
    endfunction

    // Region mostly placed on or around the current track, colour near the mean
    function automatic t_in_item near_region(input int k);
        t_in_item w;
        w = '0;
        w.region_index = ($urandom_range(9) == 0) ? IDX_BITS'($urandom_range(255))
                                                  : IDX_BITS'(k);
        if ($urandom_range(99) < 65) begin
            w.centre_x = t_coord'($urandom_range(trk.left, trk.right));
            w.centre_y = t_coord'($urandom_range(trk.top, trk.bottom));
        end else begin
            w.centre_x = t_coord'($urandom_range(1023));
            w.centre_y = t_coord'($urandom_range(1023));
        end
        if ($urandom_range(9) == 0) begin
            w.box_left   = t_coord'($urandom_range(1023));
            w.box_right  = t_coord'($urandom_range(1023));
            w.box_top    = t_coord'($urandom_range(1023));
            w.box_bottom = t_coord'($urandom_range(1023));
        end else begin
            w.box_left   = clip_coord(int'(w.centre_x) - int'($urandom_range(40)));
            w.box_right  = clip_coord(int'(w.centre_x) + int'($urandom_range(40)));
            w.box_top    = clip_coord(int'(w.centre_y) - int'($urandom_range(40)));
            w.box_bottom = clip_coord(int'(w.centre_y) + int'($urandom_range(40)));
        end
        w.mean_red   = near_colour(col_mean[0]);
        w.mean_green = near_colour(col_mean[1]);
        w.mean_blue  = near_colour(col_mean[2]);
        return w;
    endfunction

    // Offer one word, wait for its acceptance, and log what it should produce
    task automatic push_word(input t_in_item w, input bit typed, input t_out_item want);
        bit        has_res;
        t_out_item r;
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= w;
        do @(posedge i_clk); while (!in_if.ready);
        words_sent++;
        track_predict(w, has_res, r);
        if (has_res) track_q.push_back(typed ? want : r);
    endtask

    // One random frame: regions, an empty frame, or noise
    task automatic play_frame(output int sent);
        int       n_regions;
        int       pick;
        t_in_item w;
        sent = 0;
        pick = $urandom_range(99);
        if (pick < 8) begin
            w             = noise_word();
            w.frame_empty = 1'b1;
            push_word(w, 1'b0, '0);
            sent = 1;
        end else if (pick < 13) begin
            push_word(noise_word(), 1'b0, '0);
            sent = 1;
        end else begin
            n_regions = $urandom_range(1, 5);
            for (int k = 0; k < n_regions; k++) begin
                w           = near_region(k);
                w.frame_end = (k == n_regions - 1) && (pick >= 18);
                push_word(w, 1'b0, '0);
                sent++;
            end
            // a few frames closed by an empty marker after their regions
            if (pick < 18) begin
                w             = noise_word();
                w.frame_empty = 1'b1;
                push_word(w, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.payload;
            if (track_q.size() == 0) begin
                $error("result word with none expected: found %0d region %0d",
                       got.found, got.tracked_region);
                errors++;
            end else begin
                want = track_q.pop_front();
                check_field("found",          want.found,          got.found);
                check_field("tracked_region", want.tracked_region, got.tracked_region);
                check_field("out_centre_x",   want.out_centre_x,   got.out_centre_x);
                check_field("out_centre_y",   want.out_centre_y,   got.out_centre_y);
                check_field("out_left",       want.out_left,       got.out_left);
                check_field("out_right",      want.out_right,      got.out_right);
                check_field("out_top",        want.out_top,        got.out_top);
                check_field("out_bottom",     want.out_bottom,     got.out_bottom);
                if (want.found) found_cnt++;
                else            lost_cnt++;
            end
        end
    end

    // Receiver stalls
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Hang watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            hang_cycles <= 0;
        end else begin
            hang_cycles <= hang_cycles + 1;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int sent;
        int phase_words;
        int idle_src [4];
        int idle_snk [4];
        idle_src = '{0, 79, 0, 7};
        idle_snk = '{0, 0, 79, 7};
        errors        = 0;
        words_sent    = 0;
        found_cnt     = 0;
        lost_cnt      = 0;
        hang_cycles   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        trk_started   = 1'b0;
        trk_missed    = 1'b0;
        trk           = '0;
        match_cnt     = '0;
        for (int k = 0; k < N_COL; k++) begin
            col_sum[k]  = '0;
            col_mean[k] = '0;
        end
        clear_candidates();
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;

        // directed rows; typed results only where they are plain to see
        // empty frame straight after reset: lost, all zero
        dir_rows.push_back('{region(255, 1023, 1023, 1023, 1023, 1023, 1023,
                                    255, 255, 255, 1, 1), 1, '0});
        // first frame without region 0: still lost, all zero
        dir_rows.push_back('{region(5, 10, 10, 0, 20, 0, 20, 1, 2, 3, 1, 0), 1, '0});
        // first frame: first region 0 taken, a second region 0 ignored
        dir_rows.push_back('{region(0, 1023, 0, 0, 1023, 0, 1023, 255, 0, 255, 0, 0),
                             0, '0});
        dir_rows.push_back('{region(0, 7, 7, 1, 2, 3, 4, 9, 9, 9, 1, 0), 1,
                             t_out_item'{1'b1, 8'd0, 10'd1023, 10'd0, 10'd0, 10'd1023,
                                         10'd0, 10'd1023}});
        // four candidates, tie on distance keeps the earlier one
        dir_rows.push_back('{region(1, 512, 512, 500, 520, 500, 520, 10, 20, 30, 0, 0),
                             0, '0});
        dir_rows.push_back('{region(2, 100, 100, 90, 110, 90, 110, 5, 5, 5, 0, 0), 0, '0});
        dir_rows.push_back('{region(3, 0, 1023, 0, 5, 1000, 1023, 5, 5, 5, 0, 0), 0, '0});
        dir_rows.push_back('{region(4, 1023, 1023, 1000, 1023, 1000, 1023,
                                    255, 255, 255, 1, 0), 0, '0});
        // nothing inside: track lost
        dir_rows.push_back('{region(9, 500, 500, 400, 600, 400, 600, 5, 5, 5, 1, 0), 0, '0});
        // after a miss: overlap only, then inside and overlapping (counted once)
        dir_rows.push_back('{region(0, 200, 200, 100, 300, 100, 300, 200, 200, 200, 0, 0),
                             0, '0});
        dir_rows.push_back('{region(1, 95, 95, 92, 98, 92, 98, 6, 6, 6, 0, 0), 0, '0});
        // empty marker closing a frame that already holds regions
        dir_rows.push_back('{region(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, '0});
        // inverted box becomes the track
        dir_rows.push_back('{region(7, 95, 95, 600, 50, 700, 40, 5, 5, 5, 1, 0), 0, '0});
        dir_rows.push_back('{region(8, 300, 300, 0, 1023, 0, 1023, 0, 0, 0, 1, 0), 0, '0});
        dir_rows.push_back('{region(9, 0, 0, 0, 1023, 0, 1023, 255, 0, 128, 1, 0), 0, '0});
        // extreme index and colours, an inverted and a single-point region box
        dir_rows.push_back('{region(255, 1023, 1023, 1023, 0, 1023, 0, 255, 255, 255, 0, 0),
                             0, '0});
        dir_rows.push_back('{region(128, 0, 0, 1023, 1023, 1023, 1023, 0, 255, 0, 1, 0),
                             0, '0});

        // hold reset, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) push_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

        // random frames under each idling pattern
        for (int p = 0; p < 4; p++) begin
            src_idle_pct  = idle_src[p];
            snk_stall_pct = idle_snk[p];
            phase_words   = 0;
            while (phase_words < PHASE_WORDS) begin
                play_frame(sent);
                phase_words += sent;
            end
        end
        in_if.valid <= 1'b0;

        // drain
        while (track_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d region words; checked %0d frame results (%0d found, %0d lost)",
                 words_sent, found_cnt + lost_cnt, found_cnt, lost_cnt);
        $display("under four idling patterns on the input and result channels.");
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
